>>> sv/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// shared constants for the ionization source terms unit
// ----------------------------------------------------------------------------
`default_nettype none
package ist_pkg;
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC          = 16;
	localparam int RHO_W         = 31;
	localparam int DIV_STEPS     = 32;
	localparam int CFG_IDX_W     = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ELC_RATE = 3'd0,
		REG_ION_RATE = 3'd1,
		REG_ENERGY_RATE = 3'd2,
		REG_GAMMA_M1 = 3'd3,
		REG_INV_PERM = 3'd4
	} reg_idx_t;
endpackage
`default_nettype wire

>>> sv/ist_div.sv
// ----------------------------------------------------------------------------
// ist_div
// pipelined restoring divider, 64-bit dividend by 31-bit divisor, one
// quotient bit per stage, 32-bit quotient plus overflow flag
// ----------------------------------------------------------------------------
`default_nettype none
module ist_div import ist_pkg::*; #(
	parameter int PAYLOAD_W = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [63:0]          dividend,
	input  wire logic [RHO_W-1:0]     divisor,
	input  wire logic [PAYLOAD_W-1:0] in_payload,
	output logic                      out_valid,
	output logic [DIV_STEPS-1:0]      quotient,
	output logic                      overflow,
	output logic [PAYLOAD_W-1:0]      out_payload
);
	logic                 vld [0:DIV_STEPS];
	logic [RHO_W-1:0]     rem [0:DIV_STEPS];
	logic [RHO_W-1:0]     dvs [0:DIV_STEPS];
	logic [31:0]          low [0:DIV_STEPS];
	logic [DIV_STEPS-1:0] quo [0:DIV_STEPS];
	logic                 ovf [0:DIV_STEPS];
	logic [PAYLOAD_W-1:0] pay [0:DIV_STEPS];

	// quotient cannot fit 32 bits when the upper half already reaches the divisor
	always_comb begin
		vld[0] = in_valid;
		dvs[0] = divisor;
		low[0] = dividend[31:0];
		quo[0] = '0;
		pay[0] = in_payload;
		ovf[0] = dividend[63:32] >= {1'b0, divisor};
		rem[0] = ovf[0] ? '0 : dividend[62:32];
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		logic [RHO_W:0] trial;
		logic           ge;
		logic [RHO_W:0] diff;
		assign trial = {rem[k-1], low[k-1][31]};
		assign ge    = trial >= {1'b0, dvs[k-1]};
		assign diff  = trial - {1'b0, dvs[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k] <= 1'b0;
			end else if (en) begin
				vld[k] <= vld[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem[k] <= ge ? diff[RHO_W-1:0] : trial[RHO_W-1:0];
				quo[k] <= {quo[k-1][DIV_STEPS-2:0], ge};
				low[k] <= {low[k-1][30:0], 1'b0};
				dvs[k] <= dvs[k-1];
				ovf[k] <= ovf[k-1];
				pay[k] <= pay[k-1];
			end
		end
	end

	assign out_valid   = vld[DIV_STEPS];
	assign quotient    = quo[DIV_STEPS];
	assign overflow    = ovf[DIV_STEPS];
	assign out_payload = pay[DIV_STEPS];
endmodule
`default_nettype wire

>>> sv/ionization_source_terms_unit.sv
// ----------------------------------------------------------------------------
// ionization_source_terms_unit
// ionization density and energy sources for one species of a plasma cell
// ----------------------------------------------------------------------------
// One request per clock is taken, one result returned per request, in order,
// but the pipeline freezes while a result waits at the output, so nothing
// is dropped or duplicated. The pipe holds two 32-stage pipelined dividers
// (kinetic energy over density, then thermal numerator over density) and
// 13 arithmetic stages around them; the first stage forms all the squares
// and rate products side by side, the later ones hold at most one
// multiplier each. Configuration must be written through the cfg port while
// the pipe is empty; the block does not enforce it. Unknown indices are
// ignored. Zero species density returns the largest positive energy source
// and raises the saturated flag, as does any clamp of an intermediate word.
// ----------------------------------------------------------------------------
`default_nettype none
module ionization_source_terms_unit import ist_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// species_density[30:0], mom_x[62:31], mom_y[94:63], mom_z[126:95],
	// total_energy[158:127], field_x[190:159], field_y[222:191],
	// field_z[254:223], electron_density[285:255], zero pad [287:286]
	input  wire logic [287:0]         s_tdata,
	// mode[0]
	input  wire logic                 s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// density_source[31:0], energy_source[63:32]
	output logic [63:0]               m_tdata,
	// saturated[0]
	output logic                      m_tuser
);
	// saturation range follows the word size, held within 16..32 bits
	localparam int SAT = (WORD_BITS < 16) ? 16 : ((WORD_BITS > 32) ? 32 : WORD_BITS);
	localparam logic [63:0] W_MAX_U = (64'd1 << (SAT - 1)) - 64'd1;
	localparam logic [31:0] W_MAX32 = W_MAX_U[31:0];
	localparam logic [31:0] W_MIN32 = ~W_MAX32;
	localparam logic signed [64:0] W_MAX_S = $signed({1'b0, W_MAX_U});
	localparam logic signed [64:0] W_MIN_S = -W_MAX_S - 65'sd1;

	function automatic logic [32:0] sat_u(input logic [63:0] v);
		if (v > W_MAX_U) return {1'b1, W_MAX32};
		return {1'b0, v[31:0]};
	endfunction

	function automatic logic [32:0] sat_s(input logic signed [64:0] v);
		if (v > W_MAX_S) return {1'b1, W_MAX32};
		if (v < W_MIN_S) return {1'b1, W_MIN32};
		return {1'b0, v[31:0]};
	endfunction

	// configuration registers
	logic [31:0] elc_rate_q, ion_rate_q, energy_rate_q, gamma_m1_q, inv_perm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elc_rate_q    <= '0;
			ion_rate_q    <= '0;
			energy_rate_q <= '0;
			gamma_m1_q    <= '0;
			inv_perm_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ELC_RATE:    elc_rate_q    <= cfg_data;
				REG_ION_RATE:    ion_rate_q    <= cfg_data;
				REG_ENERGY_RATE: energy_rate_q <= cfg_data;
				REG_GAMMA_M1:    gamma_m1_q    <= cfg_data;
				REG_INV_PERM:    inv_perm_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipe advances unless the output holds an untaken result
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// input unpacking
	logic [RHO_W-1:0]  in_rho, in_rhoe;
	logic signed [31:0] in_mx, in_my, in_mz, in_en, in_bx, in_by, in_bz;
	assign in_rho  = s_tdata[30:0];
	assign in_mx   = s_tdata[62:31];
	assign in_my   = s_tdata[94:63];
	assign in_mz   = s_tdata[126:95];
	assign in_en   = s_tdata[158:127];
	assign in_bx   = s_tdata[190:159];
	assign in_by   = s_tdata[222:191];
	assign in_bz   = s_tdata[254:223];
	assign in_rhoe = s_tdata[285:255];

	function automatic logic [31:0] mag(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	// stage 1: squares and rate products
	logic v_s1;
	logic [63:0] smx_s1, smy_s1, smz_s1, sbx_s1, sby_s1, sbz_s1;
	logic [63:0] dens_p_s1, erho_p_s1;
	logic [RHO_W-1:0] rho_s1;
	logic signed [31:0] en_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			smx_s1    <= 64'(mag(in_mx)) * 64'(mag(in_mx));
			smy_s1    <= 64'(mag(in_my)) * 64'(mag(in_my));
			smz_s1    <= 64'(mag(in_mz)) * 64'(mag(in_mz));
			sbx_s1    <= 64'(mag(in_bx)) * 64'(mag(in_bx));
			sby_s1    <= 64'(mag(in_by)) * 64'(mag(in_by));
			sbz_s1    <= 64'(mag(in_bz)) * 64'(mag(in_bz));
			dens_p_s1 <= 64'(s_tuser ? ion_rate_q : elc_rate_q) * 64'(in_rhoe);
			erho_p_s1 <= 64'(energy_rate_q) * 64'(in_rhoe);
			rho_s1    <= in_rho;
			en_s1     <= in_en;
		end
	end

	// stage 2: sums of squares, rate saturation
	logic v_s2, flag_s2;
	logic [63:0] msum_s2, bsum_s2;
	logic [31:0] dens_s2, erho_s2;
	logic [RHO_W-1:0] rho_s2;
	logic signed [31:0] en_s2;
	logic [32:0] dens_sat, erho_sat;
	assign dens_sat = sat_u(dens_p_s1 >> FRAC);
	assign erho_sat = sat_u(erho_p_s1 >> FRAC);

	always_ff @(posedge clk) begin
		if (adv) begin
			msum_s2 <= smx_s1 + smy_s1 + smz_s1;
			bsum_s2 <= sbx_s1 + sby_s1 + sbz_s1;
			dens_s2 <= dens_sat[31:0];
			erho_s2 <= erho_sat[31:0];
			flag_s2 <= dens_sat[32] | erho_sat[32];
			rho_s2  <= rho_s1;
			en_s2   <= en_s1;
		end
	end

	// stage 3: field energy to Q16.16
	logic v_s3, flag_s3;
	logic [63:0] msum_s3;
	logic [31:0] bsq_s3, dens_s3, erho_s3;
	logic [RHO_W-1:0] rho_s3;
	logic signed [31:0] en_s3;
	logic [32:0] bsq_sat;
	assign bsq_sat = sat_u(bsum_s2 >> FRAC);

	always_ff @(posedge clk) begin
		if (adv) begin
			bsq_s3  <= bsq_sat[31:0];
			flag_s3 <= flag_s2 | bsq_sat[32];
			msum_s3 <= msum_s2;
			dens_s3 <= dens_s2;
			erho_s3 <= erho_s2;
			rho_s3  <= rho_s2;
			en_s3   <= en_s2;
		end
	end

	// stage 4: scale by reciprocal permeability
	logic v_s4, flag_s4;
	logic [63:0] msum_s4, bmu_p_s4;
	logic [31:0] dens_s4, erho_s4;
	logic [RHO_W-1:0] rho_s4;
	logic signed [31:0] en_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			bmu_p_s4 <= 64'(bsq_s3) * 64'(inv_perm_q);
			flag_s4  <= flag_s3;
			msum_s4  <= msum_s3;
			dens_s4  <= dens_s3;
			erho_s4  <= erho_s3;
			rho_s4   <= rho_s3;
			en_s4    <= en_s3;
		end
	end

	// stage 5: field term saturation
	logic v_s5, flag_s5;
	logic [63:0] msum_s5;
	logic [31:0] bmu_s5, dens_s5, erho_s5;
	logic [RHO_W-1:0] rho_s5;
	logic signed [31:0] en_s5;
	logic [32:0] bmu_sat;
	assign bmu_sat = sat_u(bmu_p_s4 >> FRAC);

	always_ff @(posedge clk) begin
		if (adv) begin
			bmu_s5  <= bmu_sat[31:0];
			flag_s5 <= flag_s4 | bmu_sat[32];
			msum_s5 <= msum_s4;
			dens_s5 <= dens_s4;
			erho_s5 <= erho_s4;
			rho_s5  <= rho_s4;
			en_s5   <= en_s4;
		end
	end

	// kinetic term: momentum squared over density
	typedef struct packed {
		logic [31:0]        bmu;
		logic signed [31:0] en;
		logic [31:0]        dens;
		logic [31:0]        erho;
		logic [RHO_W-1:0]   rho;
		logic               flag;
		logic               zero;
	} pl1_t;

	pl1_t pl1_in, pl1_out;
	logic d1_valid, d1_ovf;
	logic [DIV_STEPS-1:0] d1_q;
	assign pl1_in = '{bmu: bmu_s5, en: en_s5, dens: dens_s5, erho: erho_s5,
		rho: rho_s5, flag: flag_s5, zero: (rho_s5 == '0)};

	ist_div #(.PAYLOAD_W($bits(pl1_t))) u_div_kin (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_valid    (v_s5),
		.dividend    (msum_s5),
		.divisor     (rho_s5),
		.in_payload  (pl1_in),
		.out_valid   (d1_valid),
		.quotient    (d1_q),
		.overflow    (d1_ovf),
		.out_payload (pl1_out)
	);

	// stage 6: kinetic saturation and halving of kinetic plus field energy
	logic v_s6, flag_s6, zero_s6;
	logic [31:0] half_s6, dens_s6, erho_s6;
	logic [RHO_W-1:0] rho_s6;
	logic signed [31:0] en_s6;
	logic [32:0] kin_sat, kin_bmu;
	assign kin_sat = sat_u(d1_ovf ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(d1_q));
	assign kin_bmu = 33'(kin_sat[31:0]) + 33'(pl1_out.bmu);

	always_ff @(posedge clk) begin
		if (adv) begin
			half_s6 <= kin_bmu[32:1];
			flag_s6 <= pl1_out.flag | kin_sat[32];
			zero_s6 <= pl1_out.zero;
			dens_s6 <= pl1_out.dens;
			erho_s6 <= pl1_out.erho;
			rho_s6  <= pl1_out.rho;
			en_s6   <= pl1_out.en;
		end
	end

	// stage 7: internal energy
	logic v_s7, flag_s7, zero_s7;
	logic signed [31:0] diff_s7;
	logic [31:0] dens_s7, erho_s7;
	logic [RHO_W-1:0] rho_s7;
	logic signed [64:0] diff_w;
	logic [32:0] diff_sat;
	assign diff_w   = 65'(en_s6) - 65'(half_s6);
	assign diff_sat = sat_s(diff_w);

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s7 <= diff_sat[31:0];
			flag_s7 <= flag_s6 | diff_sat[32];
			zero_s7 <= zero_s6;
			dens_s7 <= dens_s6;
			erho_s7 <= erho_s6;
			rho_s7  <= rho_s6;
		end
	end

	// stage 8: times gamma minus one
	logic v_s8, flag_s8, zero_s8;
	logic signed [64:0] num_p_s8;
	logic [31:0] dens_s8, erho_s8;
	logic [RHO_W-1:0] rho_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_p_s8 <= 65'(diff_s7) * $signed({33'b0, gamma_m1_q});
			flag_s8  <= flag_s7;
			zero_s8  <= zero_s7;
			dens_s8  <= dens_s7;
			erho_s8  <= erho_s7;
			rho_s8   <= rho_s7;
		end
	end

	// stage 9: floor back to Q16.16 and saturate
	logic v_s9, flag_s9, zero_s9;
	logic signed [31:0] num_s9;
	logic [31:0] dens_s9, erho_s9;
	logic [RHO_W-1:0] rho_s9;
	logic [32:0] num_sat;
	assign num_sat = sat_s(num_p_s8 >>> FRAC);

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s9  <= num_sat[31:0];
			flag_s9 <= flag_s8 | num_sat[32];
			zero_s9 <= zero_s8;
			dens_s9 <= dens_s8;
			erho_s9 <= erho_s8;
			rho_s9  <= rho_s8;
		end
	end

	// stage 10: sign and magnitude for the second division
	logic v_s10, flag_s10, zero_s10, neg_s10;
	logic [31:0] nmag_s10, dens_s10, erho_s10;
	logic [RHO_W-1:0] rho_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			nmag_s10 <= mag(num_s9);
			neg_s10  <= num_s9[31];
			flag_s10 <= flag_s9;
			zero_s10 <= zero_s9;
			dens_s10 <= dens_s9;
			erho_s10 <= erho_s9;
			rho_s10  <= rho_s9;
		end
	end

	// thermal speed squared: numerator scaled up over density
	typedef struct packed {
		logic [31:0] dens;
		logic [31:0] erho;
		logic        flag;
		logic        zero;
		logic        neg;
	} pl2_t;

	pl2_t pl2_in, pl2_out;
	logic d2_valid, d2_ovf;
	logic [DIV_STEPS-1:0] d2_q;
	assign pl2_in = '{dens: dens_s10, erho: erho_s10, flag: flag_s10,
		zero: zero_s10, neg: neg_s10};

	ist_div #(.PAYLOAD_W($bits(pl2_t))) u_div_vt2 (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.in_valid    (v_s10),
		.dividend    ({16'b0, nmag_s10, 16'b0}),
		.divisor     (rho_s10),
		.in_payload  (pl2_in),
		.out_valid   (d2_valid),
		.quotient    (d2_q),
		.overflow    (d2_ovf),
		.out_payload (pl2_out)
	);

	// stage 11: signed quotient, truncated toward zero
	logic v_s11, flag_s11, zero_s11;
	logic signed [31:0] vt2_s11;
	logic [31:0] dens_s11, erho_s11;
	logic signed [64:0] vt2_w;
	logic [32:0] vt2_sat;
	assign vt2_w   = d2_ovf ? (pl2_out.neg ? -65'sd1 <<< 40 : 65'sd1 <<< 40)
		: (pl2_out.neg ? -$signed({33'b0, d2_q}) : $signed({33'b0, d2_q}));
	assign vt2_sat = sat_s(vt2_w);

	always_ff @(posedge clk) begin
		if (adv) begin
			vt2_s11  <= vt2_sat[31:0];
			flag_s11 <= pl2_out.flag | vt2_sat[32];
			zero_s11 <= pl2_out.zero;
			dens_s11 <= pl2_out.dens;
			erho_s11 <= pl2_out.erho;
		end
	end

	// stage 12: energy product
	logic v_s12, flag_s12, zero_s12;
	logic signed [64:0] e_p_s12;
	logic [31:0] dens_s12;

	always_ff @(posedge clk) begin
		if (adv) begin
			e_p_s12  <= $signed({33'b0, erho_s11}) * 65'(vt2_s11);
			flag_s12 <= flag_s11;
			zero_s12 <= zero_s11;
			dens_s12 <= dens_s11;
		end
	end

	// stage 13: output register, zero density overrides the energy source
	logic v_s13, flag_s13;
	logic [31:0] dens_s13, esrc_s13;
	logic [32:0] esrc_sat;
	assign esrc_sat = sat_s(e_p_s12 >>> FRAC);

	always_ff @(posedge clk) begin
		if (adv) begin
			esrc_s13 <= zero_s12 ? W_MAX32 : esrc_sat[31:0];
			flag_s13 <= flag_s12 | zero_s12 | esrc_sat[32];
			dens_s13 <= dens_s12;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (adv) begin
			v_s1  <= s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= d1_valid;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= d2_valid;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	assign m_tvalid = v_s13;
	assign m_tdata  = {esrc_s13, dens_s13};
	assign m_tuser  = flag_s13;
endmodule
`default_nettype wire
